/* design/tdq_pkg.sv */
// Shared constants, codes and helpers for the deadline timer queue.
package tdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_N    = 16;
  localparam int HANDLE_W    = 4;
  localparam int CAP         = (QUEUE_DEPTH < HANDLE_N) ? QUEUE_DEPTH : HANDLE_N;
  localparam int POS_W       = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W       = $clog2(CAP + 1);

  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int TAG_W   = 32;
  localparam int ENTRY_W = SEC_W + USEC_W + 1 + TAG_W;
  localparam int CFG_W   = 32;

  localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

  // Input operation codes
  localparam logic [1:0] FUNC_SCHED  = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_POLL   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_OK      = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TO_EN   = 2'd0;
  localparam logic [1:0] CFG_TO_SEC  = 2'd1;
  localparam logic [1:0] CFG_TO_USEC = 2'd2;

  // Saturate a microseconds value at its legal maximum
  function automatic logic [USEC_W-1:0] clamp_usec(input logic [USEC_W-1:0] v);
    clamp_usec = (v > USEC_MAX) ? USEC_MAX : v;
  endfunction

endpackage

/* design/tdq_if.sv */
// Valid/ready channel interfaces for requests and results.
interface tdq_in_if
  import tdq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [SEC_W-1:0]    time_sec;
  logic [USEC_W-1:0]   time_usec;
  logic                daemon;
  logic [TAG_W-1:0]    event_tag;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, func, time_sec, time_usec, daemon, event_tag, handle,
                  input ready);
  modport sink (input valid, func, time_sec, time_usec, daemon, event_tag, handle,
                output ready);
endinterface

interface tdq_out_if
  import tdq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [HANDLE_W-1:0] out_handle;
  logic [TAG_W-1:0]    out_tag;
  logic [SEC_W-1:0]    wait_sec;
  logic [USEC_W-1:0]   wait_usec;
  logic                wait_infinite;
  logic                events_pending;
  logic                idle;
  logic                last;

  modport source (output valid, kind, out_handle, out_tag, wait_sec, wait_usec,
                  wait_infinite, events_pending, idle, last, input ready);
  modport sink (input valid, kind, out_handle, out_tag, wait_sec, wait_usec,
                wait_infinite, events_pending, idle, last, output ready);
endinterface

/* design/tdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/deadline_timer_queue_core.sv */
// Top level of the deadline-sorted timer event queue.
//
//  channel | dir | transaction
//  --------+-----+------------------------------------------------------------
//  in_if   | in  | one request: schedule, cancel, poll or clear
//  out_if  | out | one result; last marks the final result of a request
//  cfg_*   | in  | single-cycle register write, no handshake
//
// Event payloads live in a handle-indexed RAM (registered read); the sorted
// order is a short list of handles. A schedule walks the queued entries
// until it sorts before one or the list ends, then inserts; a full queue,
// an unknown handle and a clear are answered at dispatch; cancel reads the
// entry, then deletes it; poll emits each expired head event, then a summary.
// The sequencer is back in idle before the next request is taken. Reset
// empties the queue at once; no clearing pass. A stalled result holds the
// sequencer in place until it is taken.
module deadline_timer_queue_core
  import tdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  tdq_in_if.sink           in_if,
  tdq_out_if.source        out_if,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISP     = 4'd1;
  localparam logic [3:0] ST_SCH_RD   = 4'd2;
  localparam logic [3:0] ST_SCH_CMP  = 4'd3;
  localparam logic [3:0] ST_SCH_INS  = 4'd4;
  localparam logic [3:0] ST_CAN_RD   = 4'd5;
  localparam logic [3:0] ST_CAN_DEL  = 4'd6;
  localparam logic [3:0] ST_POLL_RD  = 4'd7;
  localparam logic [3:0] ST_POLL_CMP = 4'd8;
  localparam logic [3:0] ST_POLL_SUM = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [1:0]          func_q;
  logic [SEC_W-1:0]    ts_q;
  logic [USEC_W-1:0]   tu_q;
  logic                dm_q;
  logic [TAG_W-1:0]    tag_q;
  logic [HANDLE_W-1:0] h_q;

  logic [CNT_W-1:0]    len_q, live_q, idx_q;
  logic [HANDLE_N-1:0] inuse_q;
  logic [HANDLE_W-1:0] order_q [CAP];
  logic [HANDLE_W-1:0] order_ins [CAP];
  logic [HANDLE_W-1:0] order_rm [CAP];

  logic [SEC_W-1:0]    ds_q, to_sec_q;
  logic [USEC_W-1:0]   du_q, to_usec_q;
  logic                pend_q, to_en_q;

  logic                out_valid_q;
  logic [1:0]          o_kind_q;
  logic [HANDLE_W-1:0] o_handle_q;
  logic [TAG_W-1:0]    o_tag_q;
  logic [SEC_W-1:0]    o_ws_q;
  logic [USEC_W-1:0]   o_wu_q;
  logic                o_inf_q, o_pend_q, o_idle_q, o_last_q;

  logic                emit;
  logic [1:0]          e_kind;
  logic [HANDLE_W-1:0] e_handle;
  logic [TAG_W-1:0]    e_tag;
  logic [SEC_W-1:0]    e_ws;
  logic [USEC_W-1:0]   e_wu;
  logic                e_inf, e_pend, e_last;

  logic                out_free, in_acc;
  logic                ram_we;
  logic [HANDLE_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [SEC_W-1:0]    ent_sec;
  logic [USEC_W-1:0]   ent_usec;
  logic                ent_dm;
  logic [TAG_W-1:0]    ent_tag;

  logic [HANDLE_W-1:0] free_h;
  logic [POS_W-1:0]    cpos, rm_pos;
  logic                full, new_before, due;
  logic [SEC_W-1:0]    dif_sec;
  logic [USEC_W-1:0]   dif_usec;

  assign out_free = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc = in_if.valid && in_if.ready;

  // Unpack the entry read from the payload RAM
  assign ent_sec  = ram_rdata[ENTRY_W-1 -: SEC_W];
  assign ent_usec = ram_rdata[TAG_W+1 +: USEC_W];
  assign ent_dm   = ram_rdata[TAG_W];
  assign ent_tag  = ram_rdata[TAG_W-1:0];

  always_comb begin
    case (state_q)
      ST_CAN_RD, ST_CAN_DEL:  ram_raddr = h_q;
      ST_SCH_RD, ST_SCH_CMP:  ram_raddr = order_q[idx_q[POS_W-1:0]];
      default:                ram_raddr = order_q[0];
    endcase
  end

  assign ram_we = (state_q == ST_SCH_INS) && out_free;

  tdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HANDLE_N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_h),
    .wdata_i ({ts_q, tu_q, dm_q, tag_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pick the lowest free handle; the queue is full only at capacity
  always_comb begin
    free_h = '0;
    for (int i = HANDLE_N - 1; i >= 0; i--) begin
      if (!inuse_q[i]) free_h = HANDLE_W'(i);
    end
  end
  assign full = (len_q == CNT_W'(CAP));

  // Locate the queued position of the handle to cancel
  always_comb begin
    cpos = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < len_q) && (order_q[i] == h_q)) cpos = POS_W'(i);
    end
  end
  assign rm_pos = (state_q == ST_CAN_DEL) ? cpos : '0;

  // Order list with the new handle inserted, and with one position dropped
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      if (POS_W'(i) == idx_q[POS_W-1:0]) begin
        order_ins[i] = free_h;
      end else if ((i > 0) && (POS_W'(i) > idx_q[POS_W-1:0])) begin
        order_ins[i] = order_q[(i > 0) ? i - 1 : 0];
      end else begin
        order_ins[i] = order_q[i];
      end
      if ((i < CAP - 1) && (POS_W'(i) >= rm_pos)) begin
        order_rm[i] = order_q[(i < CAP - 1) ? i + 1 : i];
      end else begin
        order_rm[i] = order_q[i];
      end
    end
  end

  // Time compares and the distance to the head deadline
  assign new_before = (ts_q < ent_sec) || ((ts_q == ent_sec) && (tu_q < ent_usec));
  assign due = !((ent_sec > ts_q) || ((ent_sec == ts_q) && (ent_usec > tu_q)));
  always_comb begin
    if (ent_usec >= tu_q) begin
      dif_sec  = ent_sec - ts_q;
      dif_usec = ent_usec - tu_q;
    end else begin
      dif_sec  = ent_sec - ts_q - SEC_W'(1);
      dif_usec = USEC_PER_SEC + ent_usec - tu_q;
    end
  end

  // Sequence control and result formation
  always_comb begin
    state_d  = state_q;
    emit     = 1'b0;
    e_kind   = KIND_OK;
    e_handle = '0;
    e_tag    = '0;
    e_ws     = '0;
    e_wu     = '0;
    e_inf    = 1'b0;
    e_pend   = 1'b0;
    e_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (func_q)
          FUNC_SCHED: begin
            if (full) begin
              emit   = out_free;
              e_kind = KIND_ERROR;
              if (out_free) state_d = ST_IDLE;
            end else begin
              state_d = ST_SCH_RD;
            end
          end
          FUNC_CANCEL: begin
            if (!inuse_q[h_q]) begin
              emit     = out_free;
              e_kind   = KIND_ERROR;
              e_handle = h_q;
              if (out_free) state_d = ST_IDLE;
            end else begin
              state_d = ST_CAN_RD;
            end
          end
          FUNC_CLEAR: begin
            emit = out_free;
            if (out_free) state_d = ST_IDLE;
          end
          default: state_d = ST_POLL_RD;
        endcase
      end
      ST_SCH_RD: begin
        state_d = (idx_q == len_q) ? ST_SCH_INS : ST_SCH_CMP;
      end
      ST_SCH_CMP: begin
        state_d = new_before ? ST_SCH_INS : ST_SCH_RD;
      end
      ST_SCH_INS: begin
        emit     = out_free;
        e_handle = free_h;
        if (out_free) state_d = ST_IDLE;
      end
      ST_CAN_RD: state_d = ST_CAN_DEL;
      ST_CAN_DEL: begin
        emit     = out_free;
        e_handle = h_q;
        if (out_free) state_d = ST_IDLE;
      end
      ST_POLL_RD: begin
        state_d = (len_q == '0) ? ST_POLL_SUM : ST_POLL_CMP;
      end
      ST_POLL_CMP: begin
        if (!due) begin
          state_d = ST_POLL_SUM;
        end else begin
          emit     = out_free;
          e_kind   = KIND_EXPIRED;
          e_handle = order_q[0];
          e_tag    = ent_tag;
          e_last   = 1'b0;
          if (out_free) state_d = ST_POLL_RD;
        end
      end
      ST_POLL_SUM: begin
        emit   = out_free;
        e_kind = KIND_SUMMARY;
        e_pend = pend_q;
        if (to_en_q) begin
          if (pend_q && ((ds_q < to_sec_q) || ((ds_q == to_sec_q) && (du_q < to_usec_q))))
          begin
            e_ws = ds_q;
            e_wu = du_q;
          end else begin
            e_ws = to_sec_q;
            e_wu = to_usec_q;
          end
        end else if (pend_q) begin
          e_ws = ds_q;
          e_wu = du_q;
        end else begin
          e_inf = 1'b1;
        end
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and queue bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      live_q  <= '0;
      inuse_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      to_en_q <= 1'b0;
      to_sec_q  <= '0;
      to_usec_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Take configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TO_EN:   to_en_q   <= cfg_wdata_i[0];
          CFG_TO_SEC:  to_sec_q  <= cfg_wdata_i[SEC_W-1:0];
          CFG_TO_USEC: to_usec_q <= clamp_usec(cfg_wdata_i[USEC_W-1:0]);
          default: ;
        endcase
      end

      // Hold or drop the result register
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_DISP: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
          if ((func_q == FUNC_CLEAR) && out_free) begin
            len_q   <= '0;
            live_q  <= '0;
            inuse_q <= '0;
          end
        end
        ST_SCH_CMP: begin
          if (!new_before) idx_q <= idx_q + CNT_W'(1);
        end
        ST_SCH_INS: begin
          if (out_free) begin
            len_q <= len_q + CNT_W'(1);
            inuse_q[free_h] <= 1'b1;
            if (!dm_q) live_q <= live_q + CNT_W'(1);
          end
        end
        ST_CAN_DEL: begin
          if (out_free) begin
            len_q <= len_q - CNT_W'(1);
            inuse_q[h_q] <= 1'b0;
            if (!ent_dm && (live_q != '0)) live_q <= live_q - CNT_W'(1);
          end
        end
        ST_POLL_CMP: begin
          if (!due) begin
            pend_q <= 1'b1;
          end else if (out_free) begin
            len_q <= len_q - CNT_W'(1);
            inuse_q[order_q[0]] <= 1'b0;
            if (!ent_dm && (live_q != '0)) live_q <= live_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Request fields, order list and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_if.func;
      ts_q   <= in_if.time_sec;
      tu_q   <= clamp_usec(in_if.time_usec);
      dm_q   <= in_if.daemon;
      tag_q  <= in_if.event_tag;
      h_q    <= in_if.handle;
    end
    if ((state_q == ST_SCH_INS) && out_free) begin
      order_q <= order_ins;
    end else if (((state_q == ST_CAN_DEL) && out_free) ||
                 ((state_q == ST_POLL_CMP) && due && out_free)) begin
      order_q <= order_rm;
    end
    if ((state_q == ST_POLL_CMP) && !due) begin
      ds_q <= dif_sec;
      du_q <= dif_usec;
    end
    if (emit) begin
      o_kind_q   <= e_kind;
      o_handle_q <= e_handle;
      o_tag_q    <= e_tag;
      o_ws_q     <= e_ws;
      o_wu_q     <= e_wu;
      o_inf_q    <= e_inf;
      o_pend_q   <= e_pend;
      o_idle_q   <= (e_kind == KIND_SUMMARY) && (live_q == '0);
      o_last_q   <= e_last;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = o_kind_q;
  assign out_if.out_handle     = o_handle_q;
  assign out_if.out_tag        = o_tag_q;
  assign out_if.wait_sec       = o_ws_q;
  assign out_if.wait_usec      = o_wu_q;
  assign out_if.wait_infinite  = o_inf_q;
  assign out_if.events_pending = o_pend_q;
  assign out_if.idle           = o_idle_q;
  assign out_if.last           = o_last_q;

endmodule
